@@ hdl/i8mlp_pkg.sv @@
package i8mlp_pkg;

  localparam int HIDDEN_CNT = 4;

  localparam int MULT_W    = 31;
  localparam int FRAC_BITS = 31;
  localparam int ACT_W     = 9;
  localparam int HSUM_W    = 18;
  localparam int HPROD_W   = HSUM_W + MULT_W;
  localparam int OSUM_W    = 19;
  localparam int OPROD_W   = OSUM_W + MULT_W;

  localparam int INT8_MAX = 127;
  localparam int INT8_MIN = -128;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_MULT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MULT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_ZP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_ZP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ZP   = 3'd4;

  localparam logic [MULT_W-1:0] HIDDEN_MULT_RST = 31'd7465890;
  localparam logic [MULT_W-1:0] OUTPUT_MULT_RST = 31'd8377552;
  localparam logic signed [7:0] ZP_RST          = -8'sd128;

  localparam int HID_W0 [HIDDEN_CNT] = '{101, 19, -2, 68};
  localparam int HID_W1 [HIDDEN_CNT] = '{80, -42, 2, 127};
  localparam int HID_B  [HIDDEN_CNT] = '{23675, -3548, -450, 23677};
  localparam int OUT_W  [HIDDEN_CNT] = '{127, -9, -31, 124};
  localparam int OUT_B               = 2980;

  typedef logic signed [7:0] int8_t;

endpackage

@@ hdl/int8_two_layer_dense_network_core.sv @@
// Fixed 2-4-1 int8 quantized dense network.
// The input channel carries one beat of two int8 activations; the output
// channel carries one beat of the saturated int8 network output. Both use
// valid and stall, and a beat moves when valid is high and stall is low.
// The datapath is a seven-stage pipeline: input offset, hidden dot products,
// hidden requant multiply, hidden saturate, output dot product, output
// requant multiply, output saturate. One beat is accepted every cycle while
// input stall is low. The 18x31 and 19x31 requant multipliers each have a
// stage of their own.
// When the receiver stalls, each stage holds only if the stage after it is
// full, so bubbles are squeezed out and input stall rises only once all
// seven stages hold data.
// Configuration writes take effect at the next clock edge and should be
// made while the pipeline is empty. Reset empties the pipeline and loads
// the default multipliers and zero points.
module int8_two_layer_dense_network_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [i8mlp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [i8mlp_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  i8mlp_pkg::int8_t                      first_input_i,
  input  i8mlp_pkg::int8_t                      second_input_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output i8mlp_pkg::int8_t                      network_output_o
);

  localparam int NSTG = 7;
  localparam int HN   = i8mlp_pkg::HIDDEN_CNT;

  logic [i8mlp_pkg::MULT_W-1:0] hid_mult_q, out_mult_q;
  i8mlp_pkg::int8_t             in_zp_q, hid_zp_q, out_zp_q;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic signed [i8mlp_pkg::ACT_W-1:0]   a0_q, a1_q;
  logic signed [i8mlp_pkg::HSUM_W-1:0]  hsum_d [HN];
  logic signed [i8mlp_pkg::HSUM_W-1:0]  hsum_q [HN];
  logic signed [i8mlp_pkg::HPROD_W-1:0] hprod_q [HN];
  i8mlp_pkg::int8_t                     hq [HN];
  logic signed [i8mlp_pkg::ACT_W-1:0]   hd_q [HN];
  logic signed [i8mlp_pkg::OSUM_W-1:0]  osum_d, osum_q;
  logic signed [i8mlp_pkg::OPROD_W-1:0] oprod_q;
  i8mlp_pkg::int8_t                     oq;
  i8mlp_pkg::int8_t                     out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hid_mult_q <= i8mlp_pkg::HIDDEN_MULT_RST;
      out_mult_q <= i8mlp_pkg::OUTPUT_MULT_RST;
      in_zp_q    <= i8mlp_pkg::ZP_RST;
      hid_zp_q   <= i8mlp_pkg::ZP_RST;
      out_zp_q   <= i8mlp_pkg::ZP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        i8mlp_pkg::REG_HIDDEN_MULT: hid_mult_q <= cfg_data_i;
        i8mlp_pkg::REG_OUTPUT_MULT: out_mult_q <= cfg_data_i;
        i8mlp_pkg::REG_INPUT_ZP:    in_zp_q    <= cfg_data_i[7:0];
        i8mlp_pkg::REG_HIDDEN_ZP:   hid_zp_q   <= cfg_data_i[7:0];
        i8mlp_pkg::REG_OUTPUT_ZP:   out_zp_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < HN; i++) begin
      hsum_d[i] = i8mlp_pkg::HSUM_W'(i8mlp_pkg::HID_W0[i] * a0_q
                                    + i8mlp_pkg::HID_W1[i] * a1_q
                                    + i8mlp_pkg::HID_B[i]);
    end
  end

  for (genvar g = 0; g < HN; g++) begin : g_hid
    i8mlp_requant #(
      .PW(i8mlp_pkg::HPROD_W)
    ) u_hid_rq (
      .prod_i(hprod_q[g]),
      .zp_i  (hid_zp_q),
      .q_o   (hq[g])
    );
  end

  always_comb begin
    osum_d = i8mlp_pkg::OSUM_W'(i8mlp_pkg::OUT_B);
    for (int i = 0; i < HN; i++) begin
      osum_d = osum_d + i8mlp_pkg::OSUM_W'(i8mlp_pkg::OUT_W[i] * hd_q[i]);
    end
  end

  i8mlp_requant #(
    .PW(i8mlp_pkg::OPROD_W)
  ) u_out_rq (
    .prod_i(oprod_q),
    .zp_i  (out_zp_q),
    .q_o   (oq)
  );

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a0_q <= i8mlp_pkg::ACT_W'(first_input_i) - i8mlp_pkg::ACT_W'(in_zp_q);
      a1_q <= i8mlp_pkg::ACT_W'(second_input_i) - i8mlp_pkg::ACT_W'(in_zp_q);
    end
    if (en[1]) begin
      hsum_q <= hsum_d;
    end
    if (en[2]) begin
      for (int i = 0; i < HN; i++) begin
        hprod_q[i] <= i8mlp_pkg::HPROD_W'(hsum_q[i])
                    * i8mlp_pkg::HPROD_W'($signed({1'b0, hid_mult_q}));
      end
    end
    if (en[3]) begin
      for (int i = 0; i < HN; i++) begin
        hd_q[i] <= i8mlp_pkg::ACT_W'(hq[i]) - i8mlp_pkg::ACT_W'(hid_zp_q);
      end
    end
    if (en[4]) begin
      osum_q <= osum_d;
    end
    if (en[5]) begin
      oprod_q <= i8mlp_pkg::OPROD_W'(osum_q)
               * i8mlp_pkg::OPROD_W'($signed({1'b0, out_mult_q}));
    end
    if (en[6]) begin
      out_q <= oq;
    end
  end

  assign out_valid_o      = v_q[NSTG-1];
  assign network_output_o = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat did not enter the first stage");

  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NSTG-2] && en[NSTG-1]) |=> out_valid_o)
    else $error("beat lost between the last two stages");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output is free");

endmodule

@@ hdl/i8mlp_requant.sv @@
// Adds the zero point to a Q0.31 scaled product, truncates toward zero and saturates to int8.
module i8mlp_requant #(
  parameter int PW = 49
) (
  input  logic signed [PW-1:0] prod_i,
  input  i8mlp_pkg::int8_t     zp_i,
  output i8mlp_pkg::int8_t     q_o
);

  localparam int NW = PW + 2;
  localparam int QW = NW - i8mlp_pkg::FRAC_BITS;

  logic signed [NW-1:0] num;
  logic signed [NW-1:0] adj;
  logic signed [QW-1:0] q;

  always_comb begin
    num = NW'(prod_i) + (NW'(zp_i) <<< i8mlp_pkg::FRAC_BITS);
    adj = num + $signed({{(NW-i8mlp_pkg::FRAC_BITS){1'b0}},
                         {i8mlp_pkg::FRAC_BITS{num[NW-1]}}});
    q   = $signed(adj[NW-1:i8mlp_pkg::FRAC_BITS]);
    if (q > QW'(i8mlp_pkg::INT8_MAX)) begin
      q_o = 8'(i8mlp_pkg::INT8_MAX);
    end else if (q < QW'(i8mlp_pkg::INT8_MIN)) begin
      q_o = 8'(i8mlp_pkg::INT8_MIN);
    end else begin
      q_o = 8'(q);
    end
  end

endmodule
